// ===== rtl/mcbs_pkg.sv =====
package mcbs_pkg;

   // Channel count and derived widths
   localparam int CHANNELS  = 16;
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W     = $clog2(CHANNELS + 1);

   // Fixed field widths
   localparam int OP_W      = 2;
   localparam int CHAN_W    = 4;
   localparam int TICK_W    = 16;
   localparam int LANE_W    = 16;

   // Command codes
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_REPORT
   } state_type;

   // Per-channel record held in the channel store
   typedef struct packed {
      logic              off_phase;
      logic [TICK_W-1:0] on_length;
      logic [TICK_W-1:0] off_length;
      logic [TICK_W-1:0] repeat_limit;
      logic [TICK_W-1:0] tick_counter;
      logic [TICK_W-1:0] period_counter;
   } chan_type;

   localparam int CHAN_REC_W = $bits(chan_type);

endpackage

// ===== rtl/mcbs_if.sv =====
// Command channel
interface mcbs_req_if;
   logic                               valid;
   logic                               ready;
   logic [mcbs_pkg::OP_W-1:0]          op;
   logic [mcbs_pkg::CHAN_W-1:0]        channel;
   logic [mcbs_pkg::TICK_W-1:0]        on_ticks;
   logic [mcbs_pkg::TICK_W-1:0]        off_ticks;
   logic [mcbs_pkg::TICK_W-1:0]        repeat_count;

   modport source (output valid, op, channel, on_ticks, off_ticks, repeat_count,
                   input ready);
   modport sink   (input valid, op, channel, on_ticks, off_ticks, repeat_count,
                   output ready);
endinterface

// Status channel
interface mcbs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mcbs_pkg::LANE_W-1:0]        output_levels;
   logic [mcbs_pkg::LANE_W-1:0]        active_mask;

   modport source (output valid, output_levels, active_mask, input ready);
   modport sink   (input valid, output_levels, active_mask, output ready);
endinterface

// ===== rtl/mcbs_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle
module mcbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/multi_channel_blink_sequencer.sv =====
// Channel   Dir  Beat contents
// req_bus   in   op, channel, on_ticks, off_ticks, repeat_count
// rsp_bus   out  output_levels, active_mask (one beat per command)
//
// Start/stop/unused: applied as the beat is taken, result loaded in REPORT once the
// output register is free. Tick: one store entry per cycle via the single read/write
// port pair of the store, result loaded in REPORT after the sweep. No new command is
// taken until the result is loaded. Reset clears the level and active vectors; store
// contents are used only for active channels, which a start always loads first.
// A stalled result holds in its output register while the next command is taken.
module multi_channel_blink_sequencer (
   input  logic        clock,
   input  logic        reset,
   mcbs_req_if.sink    req_bus,
   mcbs_rsp_if.source  rsp_bus
);

   // Control and per-channel flags
   mcbs_pkg::state_type              state_ff, state_in;
   logic [mcbs_pkg::CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [mcbs_pkg::CHAN_W-1:0]      proc_idx_ff, proc_idx_in;
   logic                             proc_vld_ff, proc_vld_in;
   logic [mcbs_pkg::LANE_W-1:0]      level_ff, level_in;
   logic [mcbs_pkg::LANE_W-1:0]      active_ff, active_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mcbs_pkg::LANE_W-1:0]      rsp_levels_ff, rsp_levels_in;
   logic [mcbs_pkg::LANE_W-1:0]      rsp_active_ff, rsp_active_in;

   // Store port signals
   logic                             wr_en;
   logic [mcbs_pkg::CH_W-1:0]        wr_addr;
   mcbs_pkg::chan_type               wr_rec;
   logic                             rd_en;
   logic [mcbs_pkg::CH_W-1:0]        rd_addr;
   logic [mcbs_pkg::CHAN_REC_W-1:0]  rd_data;

   // Advance datapath
   mcbs_pkg::chan_type               cur_rec;
   mcbs_pkg::chan_type               nxt_rec;
   logic [mcbs_pkg::TICK_W-1:0]      tick_inc;
   logic [mcbs_pkg::TICK_W-1:0]      per_inc;
   logic                             nxt_level;
   logic                             nxt_active;
   logic                             adv_en;

   logic                             req_fire;
   logic                             ch_ok;
   logic                             rsp_free;

   mcbs_ram #(
      .WIDTH (mcbs_pkg::CHAN_REC_W),
      .DEPTH (mcbs_pkg::CHANNELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_bus.ready         = (state_ff == mcbs_pkg::ST_IDLE);
   assign req_fire              = req_bus.valid && req_bus.ready;
   assign ch_ok                 = ({1'b0, req_bus.channel} < (mcbs_pkg::CHAN_W + 1)'(mcbs_pkg::CHANNELS));
   assign rsp_free              = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.output_levels = rsp_levels_ff;
   assign rsp_bus.active_mask   = rsp_active_ff;

   // One channel's tick: on phase, off phase, repeat count
   always_comb begin
      cur_rec    = mcbs_pkg::chan_type'(rd_data);
      nxt_rec    = cur_rec;
      nxt_level  = level_ff[proc_idx_ff];
      nxt_active = active_ff[proc_idx_ff];
      adv_en     = proc_vld_ff && active_ff[proc_idx_ff] && (cur_rec.off_length != '0);
      tick_inc   = cur_rec.tick_counter + mcbs_pkg::TICK_W'(1);
      per_inc    = cur_rec.period_counter + mcbs_pkg::TICK_W'(1);
      nxt_rec.tick_counter = tick_inc;
      if (!cur_rec.off_phase) begin
         if (tick_inc >= cur_rec.on_length) begin
            nxt_level            = 1'b0;
            nxt_rec.tick_counter = '0;
            nxt_rec.off_phase    = 1'b1;
         end
      end else if (tick_inc >= cur_rec.off_length) begin
         if (cur_rec.repeat_limit != '0) begin
            nxt_rec.period_counter = per_inc;
         end
         if ((cur_rec.repeat_limit != '0) && (per_inc >= cur_rec.repeat_limit)) begin
            nxt_active         = 1'b0;
            nxt_rec.off_length = '0;
         end else begin
            nxt_rec.tick_counter = '0;
            nxt_rec.off_phase    = 1'b0;
            nxt_level            = 1'b1;
         end
      end
   end

   // Sequencer next state, store access and result loading
   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      proc_idx_in   = proc_idx_ff;
      proc_vld_in   = 1'b0;
      level_in      = level_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_levels_in = rsp_levels_ff;
      rsp_active_in = rsp_active_ff;
      wr_en         = 1'b0;
      wr_addr       = proc_idx_ff[mcbs_pkg::CH_W-1:0];
      wr_rec        = nxt_rec;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[mcbs_pkg::CH_W-1:0];

      case (state_ff)
         mcbs_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = mcbs_pkg::ST_REPORT;
               if (req_bus.op == mcbs_pkg::OP_TICK) begin
                  state_in  = mcbs_pkg::ST_SWEEP;
                  rd_idx_in = '0;
               end else if (req_bus.op == mcbs_pkg::OP_START) begin
                  if (ch_ok && (req_bus.on_ticks != '0) && !active_ff[req_bus.channel]) begin
                     wr_en                 = 1'b1;
                     wr_addr               = req_bus.channel[mcbs_pkg::CH_W-1:0];
                     wr_rec.off_phase      = 1'b0;
                     wr_rec.on_length      = req_bus.on_ticks;
                     wr_rec.off_length     = req_bus.off_ticks;
                     wr_rec.repeat_limit   = req_bus.repeat_count;
                     wr_rec.tick_counter   = '0;
                     wr_rec.period_counter = '0;
                     active_in[req_bus.channel] = 1'b1;
                     level_in[req_bus.channel]  = 1'b1;
                  end
               end else if (req_bus.op == mcbs_pkg::OP_STOP) begin
                  if (ch_ok) begin
                     active_in[req_bus.channel] = 1'b0;
                     level_in[req_bus.channel]  = 1'b0;
                  end
               end
            end
         end

         mcbs_pkg::ST_SWEEP: begin
            // read entry i while entry i-1 is updated and written back
            if (rd_idx_ff < mcbs_pkg::CNT_W'(mcbs_pkg::CHANNELS)) begin
               rd_en       = 1'b1;
               rd_idx_in   = rd_idx_ff + mcbs_pkg::CNT_W'(1);
               proc_vld_in = 1'b1;
               proc_idx_in = mcbs_pkg::CHAN_W'(rd_idx_ff);
            end else if (!proc_vld_ff) begin
               state_in = mcbs_pkg::ST_REPORT;
            end
            if (adv_en) begin
               wr_en                  = 1'b1;
               level_in[proc_idx_ff]  = nxt_level;
               active_in[proc_idx_ff] = nxt_active;
            end
         end

         mcbs_pkg::ST_REPORT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_levels_in = level_ff;
               rsp_active_in = active_ff;
               state_in      = mcbs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mcbs_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcbs_pkg::ST_IDLE;
         rd_idx_ff    <= '0;
         proc_idx_ff  <= '0;
         proc_vld_ff  <= 1'b0;
         level_ff     <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         proc_idx_ff  <= proc_idx_in;
         proc_vld_ff  <= proc_vld_in;
         level_ff     <= level_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_levels_ff <= rsp_levels_in;
      rsp_active_ff <= rsp_active_in;
   end

endmodule

// ===== bench/mcbs_status_monitor.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the status beat for every accepted command
// and compares it with what the sequencer returns.
module mcbs_status_monitor (
   input  logic        clock,
   input  logic        reset,
   mcbs_req_if         req_mon,
   mcbs_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending_results
);
   import mcbs_pkg::*;

   // Predicted per-channel blink state
   typedef struct packed {
      logic              active;
      logic              off_phase;
      logic [TICK_W-1:0] on_len;
      logic [TICK_W-1:0] off_len;
      logic [TICK_W-1:0] rep_lim;
      logic [TICK_W-1:0] tick_cnt;
      logic [TICK_W-1:0] period_cnt;
      logic              level;
   } lamp_t;

   typedef struct packed {
      logic [LANE_W-1:0] levels;
      logic [LANE_W-1:0] active;
   } status_t;

   lamp_t   lamp [CHANNELS];
   status_t status_queue [$];

   // One tick on one channel
   function automatic lamp_t advance_lamp(lamp_t s);
      if (!s.active || s.off_len == '0)
         return s;
      s.tick_cnt = s.tick_cnt + 1'b1;
      if (!s.off_phase) begin
         if (s.tick_cnt >= s.on_len) begin
            s.level     = 1'b0;
            s.tick_cnt  = '0;
            s.off_phase = 1'b1;
         end
         return s;
      end
      if (s.tick_cnt < s.off_len)
         return s;
      if (s.rep_lim != '0) begin
         s.period_cnt = s.period_cnt + 1'b1;
         // repeat limit reached: idle, output stays off
         if (s.period_cnt >= s.rep_lim) begin
            s.active  = 1'b0;
            s.off_len = '0;
            return s;
         end
      end
      s.tick_cnt  = '0;
      s.off_phase = 1'b0;
      s.level     = 1'b1;
      return s;
   endfunction

   // Apply one command to the predicted store and return the resulting status
   function automatic status_t apply_command(logic [OP_W-1:0] op, logic [CHAN_W-1:0] ch,
                                             logic [TICK_W-1:0] on_t, logic [TICK_W-1:0] off_t,
                                             logic [TICK_W-1:0] rep);
      status_t st;
      st = '0;
      case (op)
         OP_TICK: begin
            for (int c = 0; c < CHANNELS; c++)
               lamp[c] = advance_lamp(lamp[c]);
         end
         OP_START: begin
            // zero on time or busy channel: start dropped
            if (ch < CHANNELS && on_t != '0 && !lamp[ch].active) begin
               lamp[ch]        = '0;
               lamp[ch].on_len  = on_t;
               lamp[ch].off_len = off_t;
               lamp[ch].rep_lim = rep;
               lamp[ch].active  = 1'b1;
               lamp[ch].level   = 1'b1;
            end
         end
         OP_STOP: begin
            if (ch < CHANNELS)
               lamp[ch] = '0;
         end
         default: ;
      endcase
      for (int c = 0; c < CHANNELS && c < LANE_W; c++) begin
         st.levels[c] = lamp[c].level;
         st.active[c] = lamp[c].active;
      end
      return st;
   endfunction

   // Results are checked before the command of the same edge is predicted
   always @(posedge clock) begin : watch
      status_t seen;
      status_t want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++)
            lamp[c] = '0;
         status_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.levels = rsp_mon.output_levels;
            seen.active = rsp_mon.active_mask;
            if (status_queue.size() == 0) begin
               $error("status beat with nothing expected: levels %h active %h",
                      seen.levels, seen.active);
               fail_count++;
            end else begin
               want = status_queue.pop_front();
               if (seen.levels !== want.levels) begin
                  $error("output_levels: expected %h, got %h", want.levels, seen.levels);
                  fail_count++;
               end
               if (seen.active !== want.active) begin
                  $error("active_mask: expected %h, got %h", want.active, seen.active);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            status_queue.push_back(apply_command(req_mon.op, req_mon.channel, req_mon.on_ticks,
                                                 req_mon.off_ticks, req_mon.repeat_count));
      end
      pending_results = status_queue.size();
   end

endmodule

// ===== bench/multi_channel_blink_sequencer_tb.sv =====
`timescale 1ns / 1ps

module multi_channel_blink_sequencer_tb;
   import mcbs_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 160;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned hold_off_requests;

   mcbs_req_if req_bus ();
   mcbs_rsp_if rsp_bus ();

   multi_channel_blink_sequencer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   mcbs_status_monitor u_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always #5 clock = ~clock;

   // Offer one command beat, with a random gap first; returns on acceptance
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                           input logic [TICK_W-1:0] on_t, input logic [TICK_W-1:0] off_t,
                           input logic [TICK_W-1:0] rep);
      if ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.channel      <= ch;
      req_bus.on_ticks     <= on_t;
      req_bus.off_ticks    <= off_t;
      req_bus.repeat_count <= rep;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Hold the command side until every status beat has come back
   task automatic drain_status();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
   endtask

   // Mostly short lengths so patterns run through; now and then a full-width value
   function automatic logic [TICK_W-1:0] pick_len(int unsigned short_max);
      if ($urandom_range(15) == 0)
         return TICK_W'($urandom);
      return TICK_W'($urandom_range(short_max));
   endfunction

   task automatic send_random_cmd();
      int unsigned     pick;
      logic [OP_W-1:0] op;
      pick = $urandom_range(99);
      if (pick < 55)
         op = OP_TICK;
      else if (pick < 83)
         op = OP_START;
      else if (pick < 96)
         op = OP_STOP;
      else
         op = OP_UNUSED;
      send_cmd(op, CHAN_W'($urandom_range(15)), pick_len(4), pick_len(4), pick_len(3));
   endtask

   // Result side: random back-pressure plus a long hold-off on request
   initial begin : rsp_side
      int unsigned served;
      int unsigned hold_left;
      served    = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_off_requests) begin
            served    = hold_off_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: cycles with no beat on either channel
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_TICK;
      req_bus.channel      = '0;
      req_bus.on_ticks     = '0;
      req_bus.off_ticks    = '0;
      req_bus.repeat_count = '0;
      req_idle_pct      = 11;
      rsp_idle_pct      = 68;
      hold_off_requests = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, each command, rejects and edge cases
      send_cmd(OP_TICK,   4'd0,  16'h0000, 16'h0000, 16'h0000);  // tick on empty store
      send_cmd(OP_START,  4'd0,  16'd1,    16'd1,    16'd1);     // one short period
      send_cmd(OP_TICK,   4'd9,  16'hFFFF, 16'hFFFF, 16'hFFFF);  // turns off
      send_cmd(OP_TICK,   4'd0,  16'd0,    16'd0,    16'd0);     // repeat limit hit, idle
      send_cmd(OP_START,  4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // largest lengths
      send_cmd(OP_START,  4'd3,  16'd0,    16'd5,    16'd2);     // zero on time: dropped
      send_cmd(OP_START,  4'd15, 16'd1,    16'd1,    16'd1);     // busy channel: dropped
      send_cmd(OP_START,  4'd5,  16'd2,    16'd0,    16'd0);     // steady on, no timing
      send_cmd(OP_TICK,   4'd0,  16'd0,    16'd0,    16'd0);
      send_cmd(OP_TICK,   4'd0,  16'd0,    16'd0,    16'd0);
      send_cmd(OP_STOP,   4'd5,  16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(OP_STOP,   4'd7,  16'd0,    16'd0,    16'd0);     // stop on idle channel
      send_cmd(OP_UNUSED, 4'd2,  16'd3,    16'd3,    16'd3);     // unused code: status only
      send_cmd(OP_START,  4'd1,  16'd1,    16'd2,    16'd0);     // repeats forever
      send_cmd(OP_START,  4'd2,  16'd2,    16'd1,    16'd2);
      repeat (7)
         send_cmd(OP_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
      send_cmd(OP_STOP,   4'd15, 16'd0,    16'd0,    16'd0);
      send_cmd(OP_STOP,   4'd1,  16'd0,    16'd0,    16'd0);
      drain_status();

      // Random: three idling regimes, long result hold-off early in the first
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 11; rsp_idle_pct = 68; end
            1:       begin req_idle_pct = 68; rsp_idle_pct = 11; end
            default: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 0 && i == 40)
               hold_off_requests++;
            send_random_cmd();
         end
         drain_status();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== multi_channel_blink_sequencer.f =====
rtl/mcbs_pkg.sv
rtl/mcbs_if.sv
rtl/mcbs_ram.sv
rtl/multi_channel_blink_sequencer.sv
bench/mcbs_status_monitor.sv
bench/multi_channel_blink_sequencer_tb.sv
